// ----- sv/eth_ipv4_l4_header_parser_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the header parser
// Implication checks sampled on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ETH_IPV4_L4_HEADER_PARSER_TOP_ASSERT_SVH
`define ETH_IPV4_L4_HEADER_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define EIL4P_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EIL4P_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/eil4p_pkg.sv -----
// ----------------------------------------------------------------------------
// eil4p_pkg
// Shared types and constants of the Ethernet / IPv4 / L4 header parser.
// ----------------------------------------------------------------------------
package eil4p_pkg;

    localparam int SUM_BYTE_LIMIT_DEF = 1500;
    localparam int OUT_DATA_W         = 264;

    localparam logic [15:0] ETYPE_MIN   = 16'h0600;
    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETYPE_QTAG  = 16'h8100;
    localparam logic [15:0] ETYPE_ADTAG = 16'h88A8;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // frame offsets
    localparam logic [15:0] POS_ET_HI   = 16'd12;
    localparam logic [15:0] POS_ET_LO   = 16'd13;
    localparam logic [15:0] POS_TAG_HI  = 16'd16;
    localparam logic [15:0] POS_TAG_LO  = 16'd17;
    localparam logic [15:0] LEN_ETH     = 16'd14;
    localparam logic [15:0] LEN_VLAN    = 16'd18;
    localparam logic [15:0] L3_PLAIN    = 16'd14;
    localparam logic [15:0] L3_VLAN     = 16'd18;
    localparam logic [15:0] L4_PLAIN    = 16'd34;
    localparam logic [15:0] L4_VLAN     = 16'd38;
    localparam logic [15:0] LEN_UDP_HDR = 16'd8;
    localparam logic [15:0] LEN_TCP_HDR = 16'd20;

    localparam logic [3:0] ST_ETH_SHORT   = 4'd0;
    localparam logic [3:0] ST_BELOW_MIN   = 4'd1;
    localparam logic [3:0] ST_VLAN_SHORT  = 4'd2;
    localparam logic [3:0] ST_NOT_IPV4    = 4'd3;
    localparam logic [3:0] ST_IP_SHORT    = 4'd4;
    localparam logic [3:0] ST_OTHER_PROTO = 4'd5;
    localparam logic [3:0] ST_UDP_SHORT   = 4'd6;
    localparam logic [3:0] ST_TCP_SHORT   = 4'd7;
    localparam logic [3:0] ST_UDP_OK      = 4'd8;
    localparam logic [3:0] ST_TCP_OK      = 4'd9;

    // parser state as it stands after the last byte of a frame
    typedef struct packed {
        logic [15:0] len;
        logic [15:0] outer_et;
        logic [15:0] inner_et;
        logic [63:0] addrs;     // src high
        logic [31:0] ports;     // src high
        logic [63:0] seq_ack;   // seq high
        logic [15:0] pflags;    // proto high
        logic [15:0] pay_cnt;
        logic [18:0] pay_sum;
    } t_snap;

    // result payload, first member is the most significant
    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] flow_key;
        logic [18:0] payload_sum;
        logic [15:0] payload_len;
        logic [7:0]  tcp_flags;
        logic [31:0] ack_num;
        logic [31:0] seq_num;
        logic [31:0] port_pair;
        logic [7:0]  ip_proto;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        logic [15:0] ether_type;
    } t_result;

    function automatic logic is_vlan(input logic [15:0] et);
        return (et == ETYPE_QTAG) || (et == ETYPE_ADTAG);
    endfunction

endpackage

// ----- sv/eil4p_parse.sv -----
// ----------------------------------------------------------------------------
// eil4p_parse
// Input register and per-byte header state; snapshots the state on last byte.
// ----------------------------------------------------------------------------
module eil4p_parse #(
    parameter int SUM_BYTE_LIMIT = eil4p_pkg::SUM_BYTE_LIMIT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // [7:0] data_byte
    input  logic             i_s_axis_tlast,
    output logic             o_snap_vld,
    output eil4p_pkg::t_snap o_snap,
    input  logic             i_snap_rdy
);
    import eil4p_pkg::*;

    localparam logic [2:0] PH_ETH  = 3'd0;
    localparam logic [2:0] PH_VLAN = 3'd1;
    localparam logic [2:0] PH_IP   = 3'd2;
    localparam logic [2:0] PH_L4   = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;

    localparam logic [15:0] SUM_LIM = 16'(SUM_BYTE_LIMIT);

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic [15:0] r_pos,     n_pos;
    logic [2:0]  r_phase,   n_phase;
    logic [15:0] r_outer,   n_outer;
    logic [15:0] r_inner,   n_inner;
    logic [63:0] r_addrs,   n_addrs;
    logic [31:0] r_ports,   n_ports;
    logic [63:0] r_seq_ack, n_seq_ack;
    logic [15:0] r_pflags,  n_pflags;
    logic [15:0] r_cnt,     n_cnt;
    logic [18:0] r_acc,     n_acc;

    logic        r_snap_vld;
    t_snap       r_snap;

    logic        w_snap_free;
    logic        w_go;
    logic [15:0] w_off3;
    logic [15:0] w_off4;
    logic [15:0] w_oet;
    logic [15:0] w_iet;
    logic [19:0] w_sum;
    logic [7:0]  w_proto;

    assign w_snap_free     = !r_snap_vld || i_snap_rdy;
    // a byte that closes no frame never waits on the snapshot
    assign w_go            = r_in_vld && (!r_in_last || w_snap_free);
    assign o_s_axis_tready = !r_in_vld || w_go;

    assign w_proto = r_pflags[15:8];
    assign w_oet   = {r_outer[7:0], r_in_byte};
    assign w_iet   = {r_inner[7:0], r_in_byte};
    assign w_off3  = r_pos - (is_vlan(r_outer) ? L3_VLAN : L3_PLAIN);
    assign w_off4  = r_pos - (is_vlan(r_outer) ? L4_VLAN : L4_PLAIN);
    assign w_sum   = {1'b0, r_acc} + {12'd0, r_in_byte};

    always_comb begin
        n_phase   = r_phase;
        n_outer   = r_outer;
        n_inner   = r_inner;
        n_addrs   = r_addrs;
        n_ports   = r_ports;
        n_seq_ack = r_seq_ack;
        n_pflags  = r_pflags;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_pos     = (r_pos == 16'hFFFF) ? r_pos : r_pos + 16'd1;
        case (r_phase)
            PH_ETH: begin
                if (r_pos == POS_ET_HI || r_pos == POS_ET_LO) begin
                    n_outer = w_oet;
                end
                if (r_pos == POS_ET_LO) begin
                    if (w_oet < ETYPE_MIN) begin
                        n_phase = PH_SKIP;
                    end else if (is_vlan(w_oet)) begin
                        n_phase = PH_VLAN;
                    end else begin
                        n_inner = w_oet;
                        n_phase = (w_oet == ETYPE_IPV4) ? PH_IP : PH_SKIP;
                    end
                end
            end
            PH_VLAN: begin
                if (r_pos == POS_TAG_HI || r_pos == POS_TAG_LO) begin
                    n_inner = w_iet;
                end
                if (r_pos == POS_TAG_LO) begin
                    n_phase = (w_iet == ETYPE_IPV4) ? PH_IP : PH_SKIP;
                end
            end
            PH_IP: begin
                if (w_off3 == 16'd9) begin
                    n_pflags[15:8] = r_in_byte;
                end else if (w_off3 >= 16'd12 && w_off3 <= 16'd19) begin
                    n_addrs = {r_addrs[55:0], r_in_byte};
                end
                if (w_off3 == 16'd19) begin
                    n_phase = (w_proto == PROTO_TCP || w_proto == PROTO_UDP) ? PH_L4 : PH_SKIP;
                end
            end
            PH_L4: begin
                if (w_off4 <= 16'd3) begin
                    n_ports = {r_ports[23:0], r_in_byte};
                end
                if (w_proto == PROTO_UDP) begin
                    if (w_off4 == 16'd7) begin
                        n_phase = PH_PAY;
                    end
                end else begin
                    if (w_off4 >= 16'd4 && w_off4 <= 16'd11) begin
                        n_seq_ack = {r_seq_ack[55:0], r_in_byte};
                    end else if (w_off4 == 16'd13) begin
                        n_pflags[7:0] = r_in_byte;
                    end
                    if (w_off4 == 16'd19) begin
                        n_phase = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                if (r_cnt < SUM_LIM) begin
                    n_acc = w_sum[19] ? 19'h7FFFF : w_sum[18:0];
                end
                if (r_cnt != 16'hFFFF) begin
                    n_cnt = r_cnt + 16'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_snap_vld <= 1'b0;
            r_pos      <= '0;
            r_phase    <= PH_ETH;
            r_outer    <= '0;
            r_inner    <= '0;
            r_addrs    <= '0;
            r_ports    <= '0;
            r_seq_ack  <= '0;
            r_pflags   <= '0;
            r_cnt      <= '0;
            r_acc      <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (w_snap_free) begin
                r_snap_vld <= w_go && r_in_last;
            end
            if (w_go) begin
                if (r_in_last) begin
                    // frame done: back to the start-of-frame state
                    r_pos     <= '0;
                    r_phase   <= PH_ETH;
                    r_outer   <= '0;
                    r_inner   <= '0;
                    r_addrs   <= '0;
                    r_ports   <= '0;
                    r_seq_ack <= '0;
                    r_pflags  <= '0;
                    r_cnt     <= '0;
                    r_acc     <= '0;
                end else begin
                    r_pos     <= n_pos;
                    r_phase   <= n_phase;
                    r_outer   <= n_outer;
                    r_inner   <= n_inner;
                    r_addrs   <= n_addrs;
                    r_ports   <= n_ports;
                    r_seq_ack <= n_seq_ack;
                    r_pflags  <= n_pflags;
                    r_cnt     <= n_cnt;
                    r_acc     <= n_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (w_go && r_in_last) begin
            r_snap.len      <= n_pos;
            r_snap.outer_et <= n_outer;
            r_snap.inner_et <= n_inner;
            r_snap.addrs    <= n_addrs;
            r_snap.ports    <= n_ports;
            r_snap.seq_ack  <= n_seq_ack;
            r_snap.pflags   <= n_pflags;
            r_snap.pay_cnt  <= n_cnt;
            r_snap.pay_sum  <= n_acc;
        end
    end

    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;

endmodule

// ----- sv/eil4p_fmt.sv -----
// ----------------------------------------------------------------------------
// eil4p_fmt
// Classifies a finished frame and registers the result item.
// ----------------------------------------------------------------------------
module eil4p_fmt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_snap_vld,
    input  eil4p_pkg::t_snap     i_snap,
    output logic                 o_snap_rdy,
    output logic                 o_res_vld,
    input  logic                 i_res_rdy,
    output logic [3:0]           o_res_status,
    output eil4p_pkg::t_result   o_res
);
    import eil4p_pkg::*;

    logic        r_res_vld;
    logic [3:0]  r_status;
    t_result     r_res;

    logic [3:0]  n_status;
    t_result     n_res;
    logic        w_vlan;
    logic [15:0] w_l4;
    logic [7:0]  w_proto;
    logic [31:0] w_src;
    logic [31:0] w_dst;

    assign o_snap_rdy = !r_res_vld || i_res_rdy;

    assign w_vlan  = is_vlan(i_snap.outer_et);
    assign w_l4    = w_vlan ? L4_VLAN : L4_PLAIN;
    assign w_proto = i_snap.pflags[15:8];
    assign w_src   = i_snap.addrs[63:32];
    assign w_dst   = i_snap.addrs[31:0];

    always_comb begin
        if (i_snap.len < LEN_ETH) begin
            n_status = ST_ETH_SHORT;
        end else if (i_snap.outer_et < ETYPE_MIN) begin
            n_status = ST_BELOW_MIN;
        end else if (w_vlan && i_snap.len < LEN_VLAN) begin
            n_status = ST_VLAN_SHORT;
        end else if (i_snap.inner_et != ETYPE_IPV4) begin
            n_status = ST_NOT_IPV4;
        end else if (i_snap.len < w_l4) begin
            n_status = ST_IP_SHORT;
        end else if (w_proto == PROTO_UDP) begin
            n_status = (i_snap.len < w_l4 + LEN_UDP_HDR) ? ST_UDP_SHORT : ST_UDP_OK;
        end else if (w_proto == PROTO_TCP) begin
            n_status = (i_snap.len < w_l4 + LEN_TCP_HDR) ? ST_TCP_SHORT : ST_TCP_OK;
        end else begin
            n_status = ST_OTHER_PROTO;
        end
    end

    // fields of headers that did not fit read as zero
    always_comb begin
        n_res = '0;
        if (n_status >= ST_BELOW_MIN) begin
            n_res.ether_type = i_snap.outer_et;
        end
        if (n_status >= ST_OTHER_PROTO) begin
            n_res.src_addr = w_src;
            n_res.dst_addr = w_dst;
            n_res.ip_proto = w_proto;
        end
        if (n_status == ST_UDP_OK || n_status == ST_TCP_OK) begin
            n_res.port_pair   = i_snap.ports;
            n_res.payload_len = i_snap.pay_cnt;
            n_res.payload_sum = i_snap.pay_sum;
            n_res.flow_key    = w_src ^ w_dst ^ {16'd0, i_snap.ports[31:16]}
                              ^ {16'd0, i_snap.ports[15:0]} ^ {24'd0, w_proto};
        end
        if (n_status == ST_TCP_OK) begin
            n_res.seq_num   = i_snap.seq_ack[63:32];
            n_res.ack_num   = i_snap.seq_ack[31:0];
            n_res.tcp_flags = i_snap.pflags[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (o_snap_rdy) begin
            r_res_vld <= i_snap_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_rdy && i_snap_vld) begin
            r_status <= n_status;
            r_res    <= n_res;
        end
    end

    assign o_res_vld    = r_res_vld;
    assign o_res_status = r_status;
    assign o_res        = r_res;

endmodule

// ----- sv/eth_ipv4_l4_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser_top
// Ethernet / VLAN / IPv4 / TCP-UDP header parser, one frame byte per item.
// ----------------------------------------------------------------------------
// Throughput: one byte item per cycle; a last byte waits on a held snapshot.
// Per-byte state is registered. After the last byte is accepted, the result
//   passes the input register, then frame snapshot, then result register.
// Reset: synchronous, active low; empties all stages and returns the parser to
//   the start of a frame.
module eth_ipv4_l4_header_parser_top #(
    parameter int SUM_BYTE_LIMIT = eil4p_pkg::SUM_BYTE_LIMIT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tlast,   // last_byte
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [15:0] ether_type, [47:16] src_addr, [79:48] dst_addr, [87:80] ip_proto,
    // [119:88] port_pair, [151:120] seq_num, [183:152] ack_num,
    // [191:184] tcp_flags, [207:192] payload_len, [226:208] payload_sum,
    // [258:227] flow_key, [263:259] zero
    output logic [263:0] o_m_axis_tdata,
    output logic [3:0]   o_m_axis_tuser    // [3:0] status
);
    import eil4p_pkg::*;

    logic    w_snap_vld;
    logic    w_snap_rdy;
    t_snap   w_snap;
    t_result w_res;

    eil4p_parse #(
        .SUM_BYTE_LIMIT (SUM_BYTE_LIMIT)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_snap_vld      (w_snap_vld),
        .o_snap          (w_snap),
        .i_snap_rdy      (w_snap_rdy)
    );

    eil4p_fmt u_fmt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_vld   (w_snap_vld),
        .i_snap       (w_snap),
        .o_snap_rdy   (w_snap_rdy),
        .o_res_vld    (o_m_axis_tvalid),
        .i_res_rdy    (i_m_axis_tready),
        .o_res_status (o_m_axis_tuser),
        .o_res        (w_res)
    );

    assign o_m_axis_tdata = w_res;

`include "eth_ipv4_l4_header_parser_top_assert.svh"

    `EIL4P_ASSERT_NOW(a_status_range, o_m_axis_tvalid, o_m_axis_tuser <= ST_TCP_OK, "status out of range")
    `EIL4P_ASSERT_NOW(a_no_ip_fields, o_m_axis_tvalid && o_m_axis_tuser < ST_OTHER_PROTO, o_m_axis_tdata[87:16] == '0, "IP fields set without an IPv4 header")
    `EIL4P_ASSERT_NOW(a_no_l4_fields, o_m_axis_tvalid && o_m_axis_tuser != ST_UDP_OK && o_m_axis_tuser != ST_TCP_OK, o_m_axis_tdata[263:88] == '0, "L4 fields set without a full L4 header")
    `EIL4P_ASSERT_NEXT(a_snap_drains, w_snap_vld && w_snap_rdy && !(o_s_axis_tready && i_s_axis_tvalid && i_s_axis_tlast), o_m_axis_tvalid, "frame snapshot lost")

endmodule
